FILE: rtl/core/spa_pkg.sv
`default_nettype none

package spa_pkg;

    localparam int COEF_W = 32;
    localparam int EXPO_W = 8;
    localparam int TERM_W = COEF_W + EXPO_W;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MERGE  = 2'd2;

    localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [EXPO_W-1:0]        expo;
        logic signed [COEF_W-1:0] coef;
    } term_t;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/sparse_polynomial_add_top.sv
// Sparse polynomial adder.
// The slave channel carries one transaction per term or command. s_tuser holds the mode:
// 0 appends the term in s_tdata to the first polynomial, 1 appends it to the second, and
// 2 merges both and streams the sum out of the master channel. Appends are taken one per
// cycle while idle (s_tready high) and produce nothing; an append to a full store is
// dropped and remembered. A merge enters the merge state, where each step loads one
// result into the output register: one per cycle while the receiver takes them, one term
// of each store being read from its memory port per step. s_tready stays low until the
// final result is loaded. Results are in descending exponent order, with m_tlast on the
// final one; two empty polynomials give a single result with term_valid clear.
// When m_tready is low the output register holds its transaction and the merge waits;
// appends are still taken while a finished result waits to be collected.
// The merge empties both stores and clears the dropped-term flag.
// Reset empties both stores and clears the flag; no memory clearing pass is needed.
module sparse_polynomial_add_top #(
    parameter int MAX_TERMS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // term_coefficient [31:0], term_exponent [39:32]
    input  wire  [1:0]  s_tuser,   // mode [1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // sum_coefficient [31:0], sum_exponent [39:32]
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // term_valid [0], terms_dropped [1]
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

    spa_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, i_inc, j_inc;
    logic             ovf_reg, ovf_next;

    logic             m_valid_reg, m_valid_next;
    spa_pkg::term_t   m_term_reg, m_term_next;
    logic             m_tv_reg, m_tv_next;
    logic             m_last_reg, m_last_next;
    logic             m_drop_reg, m_drop_next;

    spa_pkg::term_t   in_term, rd_a, rd_b;
    logic             s_fire, out_free, step;
    logic             a_has, b_has, take_a, take_b, last;
    logic             wr_a, wr_b;
    logic signed [spa_pkg::COEF_W:0] sum_wide;
    logic signed [spa_pkg::COEF_W-1:0] sum_sat;

    assign in_term  = spa_pkg::term_t'(s_tdata);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    spa_store #(.DEPTH(MAX_TERMS)) u_store_a (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (cnt_a_reg[IDX_W-1:0]),
        .wr_data (in_term),
        .rd_addr (i_next[IDX_W-1:0]),
        .rd_data (rd_a)
    );

    spa_store #(.DEPTH(MAX_TERMS)) u_store_b (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (cnt_b_reg[IDX_W-1:0]),
        .wr_data (in_term),
        .rd_addr (j_next[IDX_W-1:0]),
        .rd_data (rd_b)
    );

    always_comb begin
        sum_wide = {rd_a.coef[spa_pkg::COEF_W-1], rd_a.coef}
                 + {rd_b.coef[spa_pkg::COEF_W-1], rd_b.coef};
        if (sum_wide[spa_pkg::COEF_W] != sum_wide[spa_pkg::COEF_W-1]) begin
            sum_sat = sum_wide[spa_pkg::COEF_W] ? spa_pkg::COEF_MIN : spa_pkg::COEF_MAX;
        end else begin
            sum_sat = sum_wide[spa_pkg::COEF_W-1:0];
        end
    end

    always_comb begin
        a_has  = i_reg < cnt_a_reg;
        b_has  = j_reg < cnt_b_reg;
        take_a = 1'b0;
        take_b = 1'b0;
        priority if (a_has && b_has && rd_a.expo == rd_b.expo) begin
            take_a = 1'b1;
            take_b = 1'b1;
        end else if (a_has && (!b_has || rd_a.expo > rd_b.expo)) begin
            take_a = 1'b1;
        end else begin
            take_b = b_has;
        end
        i_inc = i_reg + CNT_W'(take_a);
        j_inc = j_reg + CNT_W'(take_b);
        last  = (i_inc >= cnt_a_reg) && (j_inc >= cnt_b_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spa_pkg::ST_IDLE: begin
                if (s_fire && s_tuser == spa_pkg::MODE_MERGE) begin
                    state_next = spa_pkg::ST_MERGE;
                end
            end
            spa_pkg::ST_MERGE: begin
                if (out_free && last) begin
                    state_next = spa_pkg::ST_IDLE;
                end
            end
            default: state_next = spa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == spa_pkg::ST_IDLE);
        step     = (state_reg == spa_pkg::ST_MERGE) && out_free;
        wr_a     = s_fire && s_tuser == spa_pkg::MODE_FIRST && cnt_a_reg < CNT_MAX;
        wr_b     = s_fire && s_tuser == spa_pkg::MODE_SECOND && cnt_b_reg < CNT_MAX;

        cnt_a_next = cnt_a_reg + CNT_W'(wr_a);
        cnt_b_next = cnt_b_reg + CNT_W'(wr_b);
        ovf_next   = ovf_reg
                   || (s_fire && s_tuser == spa_pkg::MODE_FIRST && !wr_a)
                   || (s_fire && s_tuser == spa_pkg::MODE_SECOND && !wr_b);
        i_next     = i_reg;
        j_next     = j_reg;

        m_valid_next = m_valid_reg && !m_tready;
        m_term_next  = m_term_reg;
        m_tv_next    = m_tv_reg;
        m_last_next  = m_last_reg;
        m_drop_next  = m_drop_reg;

        if (step) begin
            m_valid_next = 1'b1;
            m_tv_next    = take_a || take_b;
            m_last_next  = last;
            m_drop_next  = ovf_reg;
            if (take_a && take_b) begin
                m_term_next.coef = sum_sat;
                m_term_next.expo = rd_a.expo;
            end else if (take_a) begin
                m_term_next = rd_a;
            end else if (take_b) begin
                m_term_next = rd_b;
            end else begin
                m_term_next = '0;
            end
            if (last) begin
                i_next     = '0;
                j_next     = '0;
                cnt_a_next = '0;
                cnt_b_next = '0;
                ovf_next   = 1'b0;
            end else begin
                i_next = i_inc;
                j_next = j_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spa_pkg::ST_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_term_reg <= m_term_next;
        m_tv_reg   <= m_tv_next;
        m_last_reg <= m_last_next;
        m_drop_reg <= m_drop_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_term_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_drop_reg, m_tv_reg};

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_a_reg <= CNT_MAX && cnt_b_reg <= CNT_MAX)
        else $error("Term count exceeds the store depth.");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        i_reg <= cnt_a_reg && j_reg <= cnt_b_reg)
        else $error("Merge index has run past its store.");

    a_merge_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && last) |=> (cnt_a_reg == '0 && cnt_b_reg == '0 && !ovf_reg))
        else $error("Stores not emptied at the end of a merge.");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("Empty-result marker without the last mark.");

endmodule

`default_nettype wire

FILE: rtl/core/spa_store.sv
`default_nettype none

module spa_store #(
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                 aclk,
    input  wire                 wr_en,
    input  wire [ADDR_W-1:0]    wr_addr,
    input  spa_pkg::term_t      wr_data,
    input  wire [ADDR_W-1:0]    rd_addr,
    output spa_pkg::term_t      rd_data
);

    spa_pkg::term_t mem [DEPTH];
    spa_pkg::term_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
